FILE: src/ffn_linear_relu_linear_assert.svh
// Assertion macros for the feed-forward block's top-level RTL file.
// Needs clk and rst_n in scope at the point of use; empty under SYNTHESIS.
`ifndef FFN_LINEAR_RELU_LINEAR_ASSERT_SVH
`define FFN_LINEAR_RELU_LINEAR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define FFN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffn_linear_relu_linear: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FFN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffn_linear_relu_linear: assertion failed");

`else

`define FFN_ASSERT_SAME(label, ante, cons)
`define FFN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/ffn_pkg.sv
// Package for the feed-forward block: beat payloads, sequencer states,
// and the control and operand bundles passed between submodules. No dependencies.
`timescale 1ns / 1ps

package ffn_pkg;

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned INDEX_W = 6;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_ACT   = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_W-1:0]        weight_addr;
    logic signed [DATA_W-1:0] value;
    logic                     in_last;
  } ffn_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [INDEX_W-1:0]       out_index;
    logic                     out_last;
  } ffn_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } ffn_state_t;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic layer2;
  } ffn_ctl_t;

  // Storage side effects ordered by the sequencer.
  typedef struct packed {
    logic hid_we;
    logic tok_clr;
  } ffn_evt_t;

  // Operands read from storage, aligned with their step flags.
  typedef struct packed {
    logic                     vld;
    logic                     first;
    logic                     last;
    logic                     layer2;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] bias;
  } ffn_op_t;

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] value;
  } ffn_res_t;

endpackage

FILE: src/ffn_seq.sv
// Sequencer of the feed-forward block: walks rows and columns of both layers
// and issues one MAC step per cycle unless waiting. Depends on ffn_pkg.
`timescale 1ns / 1ps

module ffn_seq import ffn_pkg::*; #(
  parameter int EMBED_DIM  = 16,
  parameter int HIDDEN_LEN = 64,
  localparam int MAXN    = (EMBED_DIM > HIDDEN_LEN) ? EMBED_DIM : HIDDEN_LEN,
  localparam int CNT_W   = $clog2(MAXN),
  localparam int WADDR_W = $clog2(EMBED_DIM * HIDDEN_LEN)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               res_vld,
  input  logic               out_stall,
  output ffn_ctl_t           ctl,
  output ffn_evt_t           evt,
  output logic               busy,
  output logic               out_valid,
  output logic [CNT_W-1:0]   row,
  output logic [CNT_W-1:0]   col,
  output logic [WADDR_W-1:0] waddr
);

  localparam logic [CNT_W-1:0]   E_LAST = CNT_W'(EMBED_DIM - 1);
  localparam logic [CNT_W-1:0]   H_LAST = CNT_W'(HIDDEN_LEN - 1);
  localparam logic [WADDR_W-1:0] E_STEP = WADDR_W'(EMBED_DIM);
  localparam logic [WADDR_W-1:0] H_STEP = WADDR_W'(HIDDEN_LEN);

  ffn_state_t         state_r, state_nxt;
  logic               layer2_r, layer2_nxt;
  logic [CNT_W-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [WADDR_W-1:0] waddr_r, waddr_nxt;
  logic               col_end;
  logic               row_end;

  assign col_end = layer2_r ? (col_r == H_LAST) : (col_r == E_LAST);
  assign row_end = layer2_r ? (row_r == E_LAST) : (row_r == H_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (col_end) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (res_vld) state_nxt = layer2_r ? ST_OUT : ST_ISSUE;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = row_end ? ST_IDLE : ST_ISSUE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    layer2_nxt = layer2_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    waddr_nxt  = waddr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          layer2_nxt = 1'b0;
          row_nxt    = '0;
          col_nxt    = '0;
          waddr_nxt  = '0;
        end
      end
      ST_ISSUE: begin
        col_nxt   = col_r + 1'b1;
        waddr_nxt = waddr_r + (layer2_r ? E_STEP : H_STEP);
      end
      ST_WAIT: begin
        if (res_vld && !layer2_r) begin
          col_nxt = '0;
          if (row_end) begin
            layer2_nxt = 1'b1;
            row_nxt    = '0;
            waddr_nxt  = '0;
          end else begin
            row_nxt   = row_r + 1'b1;
            waddr_nxt = WADDR_W'(row_r) + WADDR_W'(1);
          end
        end
      end
      ST_OUT: begin
        if (!out_stall && !row_end) begin
          row_nxt   = row_r + 1'b1;
          col_nxt   = '0;
          waddr_nxt = WADDR_W'(row_r) + WADDR_W'(1);
        end
      end
      default: begin
        col_nxt = '0;
      end
    endcase
  end

  always_comb begin
    ctl.vld     = (state_r == ST_ISSUE);
    ctl.first   = (col_r == '0);
    ctl.last    = col_end;
    ctl.layer2  = layer2_r;
    evt.hid_we  = (state_r == ST_WAIT) && res_vld && !layer2_r;
    evt.tok_clr = (state_r == ST_OUT) && !out_stall && row_end;
    busy        = (state_r != ST_IDLE);
    out_valid   = (state_r == ST_OUT);
    row         = row_r;
    col         = col_r;
    waddr       = waddr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      layer2_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      waddr_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      layer2_r <= layer2_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      waddr_r  <= waddr_nxt;
    end
  end

endmodule

FILE: src/ffn_store.sv
// Weight, bias, token and hidden storage of the feed-forward block, with
// registered reads that feed the shared MAC. Depends on ffn_pkg.
`timescale 1ns / 1ps

module ffn_store import ffn_pkg::*; #(
  parameter int EMBED_DIM  = 16,
  parameter int HIDDEN_LEN = 64,
  localparam int MAXN    = (EMBED_DIM > HIDDEN_LEN) ? EMBED_DIM : HIDDEN_LEN,
  localparam int CNT_W   = $clog2(MAXN),
  localparam int WADDR_W = $clog2(EMBED_DIM * HIDDEN_LEN)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic                     act_en,
  input  ffn_in_t                  in_data,
  input  ffn_ctl_t                 ctl,
  input  ffn_evt_t                 evt,
  input  logic [CNT_W-1:0]         row,
  input  logic [CNT_W-1:0]         col,
  input  logic [WADDR_W-1:0]       waddr,
  input  logic signed [DATA_W-1:0] hid_wdata,
  output ffn_op_t                  op
);

  localparam int W_WORDS = EMBED_DIM * HIDDEN_LEN;
  localparam int EW      = $clog2(EMBED_DIM);
  localparam int HW      = $clog2(HIDDEN_LEN);
  localparam int CW      = $clog2(EMBED_DIM + 1);

  localparam logic [31:0] W2_BASE  = 32'(W_WORDS);
  localparam logic [31:0] B1_BASE  = 32'(2 * W_WORDS);
  localparam logic [31:0] B2_BASE  = 32'(2 * W_WORDS + HIDDEN_LEN);
  localparam logic [31:0] ADDR_END = 32'(2 * W_WORDS + HIDDEN_LEN + EMBED_DIM);
  localparam logic [CW-1:0] TOK_FULL = CW'(EMBED_DIM);

  logic signed [DATA_W-1:0] w1_mem  [W_WORDS];
  logic signed [DATA_W-1:0] w2_mem  [W_WORDS];
  logic signed [DATA_W-1:0] b1_mem  [HIDDEN_LEN];
  logic signed [DATA_W-1:0] b2_mem  [EMBED_DIM];
  logic signed [DATA_W-1:0] tok_mem [EMBED_DIM];
  logic signed [DATA_W-1:0] hid_mem [HIDDEN_LEN];

  logic [HIDDEN_LEN-1:0] b1_vld_r;
  logic [EMBED_DIM-1:0]  b2_vld_r;
  logic [CW-1:0]         tok_cnt_r;
  ffn_ctl_t              ctl_q_r;

  logic signed [DATA_W-1:0] w1_q, w2_q, b1_q, b2_q, x_q, hid_q;

  logic [31:0] addr_ext, w2_off, b1_off, b2_off;
  logic        w1_we, w2_we, b1_we, b2_we, tok_we;

  // Decode the flat weight address into one of the four stores; drop writes past the map.
  always_comb begin
    addr_ext = {20'b0, in_data.weight_addr};
    w2_off   = addr_ext - W2_BASE;
    b1_off   = addr_ext - B1_BASE;
    b2_off   = addr_ext - B2_BASE;
    w1_we    = 1'b0;
    w2_we    = 1'b0;
    b1_we    = 1'b0;
    b2_we    = 1'b0;
    if (wr_en && (addr_ext < ADDR_END)) begin
      priority if (addr_ext < W2_BASE) w1_we = 1'b1;
      else if (addr_ext < B1_BASE)     w2_we = 1'b1;
      else if (addr_ext < B2_BASE)     b1_we = 1'b1;
      else                             b2_we = 1'b1;
    end
    tok_we = act_en && (tok_cnt_r < TOK_FULL);
  end

  always_ff @(posedge clk) begin
    if (w1_we)      w1_mem[addr_ext[WADDR_W-1:0]] <= in_data.value;
    if (w2_we)      w2_mem[w2_off[WADDR_W-1:0]]   <= in_data.value;
    if (b1_we)      b1_mem[b1_off[HW-1:0]]        <= in_data.value;
    if (b2_we)      b2_mem[b2_off[EW-1:0]]        <= in_data.value;
    if (tok_we)     tok_mem[tok_cnt_r[EW-1:0]]    <= in_data.value;
    if (evt.hid_we) hid_mem[row[HW-1:0]]          <= hid_wdata;
  end

  // Registered reads; unwritten biases and token slots read as zero.
  always_ff @(posedge clk) begin
    w1_q  <= w1_mem[waddr];
    w2_q  <= w2_mem[waddr];
    b1_q  <= b1_vld_r[row[HW-1:0]] ? b1_mem[row[HW-1:0]] : '0;
    b2_q  <= b2_vld_r[row[EW-1:0]] ? b2_mem[row[EW-1:0]] : '0;
    x_q   <= (CW'(col[EW-1:0]) < tok_cnt_r) ? tok_mem[col[EW-1:0]] : '0;
    hid_q <= hid_mem[col[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= '0;
      b2_vld_r  <= '0;
      tok_cnt_r <= '0;
      ctl_q_r   <= '0;
    end else begin
      if (b1_we) b1_vld_r[b1_off[HW-1:0]] <= 1'b1;
      if (b2_we) b2_vld_r[b2_off[EW-1:0]] <= 1'b1;
      if (evt.tok_clr) begin
        tok_cnt_r <= '0;
      end else if (tok_we) begin
        tok_cnt_r <= tok_cnt_r + 1'b1;
      end
      ctl_q_r <= ctl;
    end
  end

  always_comb begin
    op.vld    = ctl_q_r.vld;
    op.first  = ctl_q_r.first;
    op.last   = ctl_q_r.last;
    op.layer2 = ctl_q_r.layer2;
    op.a      = ctl_q_r.layer2 ? hid_q : x_q;
    op.b      = ctl_q_r.layer2 ? w2_q : w1_q;
    op.bias   = ctl_q_r.layer2 ? b2_q : b1_q;
  end

endmodule

FILE: src/ffn_mac.sv
// Shared multiply-accumulate unit: product, accumulate with bias preload,
// floor shift, 16-bit saturation and ReLU for the hidden layer. Depends on ffn_pkg.
`timescale 1ns / 1ps

module ffn_mac import ffn_pkg::*; #(
  parameter int EMBED_DIM  = 16,
  parameter int HIDDEN_LEN = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ffn_op_t  op,
  output ffn_res_t res
);

  localparam int MAXN   = (EMBED_DIM > HIDDEN_LEN) ? EMBED_DIM : HIDDEN_LEN;
  localparam int ACC_W  = 33 + $clog2(MAXN + 1);
  localparam int PROD_W = 2 * DATA_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] bias_r;
  logic                     p_vld_r, p_first_r, p_last_r, p_layer2_r;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_base, bias_ext, prod_ext, shifted;
  logic                     done_r, done_layer2_r;

  logic                     sat_hi, sat_lo;
  logic signed [DATA_W-1:0] sat_val, res_nxt;
  logic signed [DATA_W-1:0] res_val_r;
  logic                     res_vld_r;

  always_comb begin
    bias_ext = {{(ACC_W - DATA_W){bias_r[DATA_W-1]}}, bias_r};
    prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    acc_base = p_first_r ? (bias_ext <<< FRAC_BITS) : acc_r;
    acc_nxt  = acc_base + prod_ext;
  end

  // Floor shift, clamp to the signed 16-bit range, then ReLU for the hidden layer.
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:DATA_W-1]);
    sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:DATA_W-1]);
    priority if (sat_hi) sat_val = 16'sh7FFF;
    else if (sat_lo)     sat_val = 16'sh8000;
    else                 sat_val = shifted[DATA_W-1:0];
    res_nxt = (!done_layer2_r && sat_val[DATA_W-1]) ? '0 : sat_val;
  end

  always_ff @(posedge clk) begin
    prod_r        <= $signed(op.a) * $signed(op.b);
    bias_r        <= op.bias;
    p_first_r     <= op.first;
    p_last_r      <= op.last;
    p_layer2_r    <= op.layer2;
    done_layer2_r <= p_layer2_r;
    if (p_vld_r) acc_r <= acc_nxt;
    if (done_r)  res_val_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      done_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= op.vld;
      done_r    <= p_vld_r && p_last_r;
      res_vld_r <= done_r;
    end
  end

  assign res.vld   = res_vld_r;
  assign res.value = res_val_r;

endmodule

FILE: src/ffn_linear_relu_linear.sv
// Top level of the two-layer ReLU feed-forward block for one token vector.
// Depends on ffn_pkg, ffn_seq, ffn_store, ffn_mac and the assertion header.
`timescale 1ns / 1ps
`include "ffn_linear_relu_linear_assert.svh"

//  channel  | ports                          | beat carries
//  ---------+--------------------------------+----------------------------------------
//  input    | in_valid, in_stall, in_data    | weight/bias write or one token element
//  output   | out_valid, out_stall, out_data | one output element y[k] with index, last
//
//  A write beat or an activation beat without last is taken whenever the block is idle.
//  An activation beat with last starts the compute: one shared 16x16 multiplier
//  does every MAC of both layers. in_stall stays high for the whole compute;
//  each output beat waits in place under out_stall. Reset clears bias valid
//  bits and the token fill count.

module ffn_linear_relu_linear import ffn_pkg::*; #(
  parameter int EMBED_DIM  = 16,
  parameter int HIDDEN_LEN = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ffn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ffn_out_t out_data
);

  localparam int MAXN    = (EMBED_DIM > HIDDEN_LEN) ? EMBED_DIM : HIDDEN_LEN;
  localparam int CNT_W   = $clog2(MAXN);
  localparam int WADDR_W = $clog2(EMBED_DIM * HIDDEN_LEN);
  localparam logic [CNT_W-1:0] E_LAST = CNT_W'(EMBED_DIM - 1);

  logic               busy;
  logic               in_beat, wr_en, act_en, start;
  ffn_ctl_t           ctl;
  ffn_evt_t           evt;
  ffn_op_t            op;
  ffn_res_t           mac_res;
  logic [CNT_W-1:0]   row, col;
  logic [WADDR_W-1:0] waddr;

  // Take input only while idle; the last activation beat kicks off compute.
  assign in_stall = busy;
  assign in_beat  = in_valid && !in_stall;
  assign wr_en    = in_beat && (in_data.req_type == REQ_WRITE);
  assign act_en   = in_beat && (in_data.req_type == REQ_ACT);
  assign start    = act_en && in_data.in_last;

  ffn_seq #(
    .EMBED_DIM  (EMBED_DIM),
    .HIDDEN_LEN (HIDDEN_LEN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .res_vld   (mac_res.vld),
    .out_stall (out_stall),
    .ctl       (ctl),
    .evt       (evt),
    .busy      (busy),
    .out_valid (out_valid),
    .row       (row),
    .col       (col),
    .waddr     (waddr)
  );

  // Storage: weights, biases, token and hidden vectors, registered reads.
  ffn_store #(
    .EMBED_DIM  (EMBED_DIM),
    .HIDDEN_LEN (HIDDEN_LEN)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .act_en    (act_en),
    .in_data   (in_data),
    .ctl       (ctl),
    .evt       (evt),
    .row       (row),
    .col       (col),
    .waddr     (waddr),
    .hid_wdata (mac_res.value),
    .op        (op)
  );

  // Shared MAC; its result register also holds the output beat under stall.
  ffn_mac #(
    .EMBED_DIM  (EMBED_DIM),
    .HIDDEN_LEN (HIDDEN_LEN),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (mac_res)
  );

  always_comb begin
    out_data.out_value = mac_res.value;
    out_data.out_index = INDEX_W'(row);
    out_data.out_last  = (row == E_LAST);
  end

  // No input is taken while a result waits.
  `FFN_ASSERT_SAME(a_no_input_during_out, out_valid, in_stall)
  // The final output beat returns the block to idle.
  `FFN_ASSERT_NEXT(a_last_returns_idle, out_valid && !out_stall && out_data.out_last, !in_stall)
  // Every further output needs a fresh accumulation first.
  `FFN_ASSERT_NEXT(a_out_gap, out_valid && !out_stall && !out_data.out_last, !out_valid)
  // A MAC result only arrives while the sequencer waits on it.
  `FFN_ASSERT_SAME(a_result_in_wait, mac_res.vld, in_stall && !out_valid)

endmodule
